// File: rtl/rtrs_pkg.sv
// Shared types and constants for the run table reposition scan.
// No dependencies; imported by every rtl module of the block.
`default_nettype none
package rtrs_pkg;

  localparam int unsigned MAX_RUNS = 4096;
  localparam int unsigned IDX_W    = $clog2(MAX_RUNS);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned STEP_W   = 12;

  localparam logic [CNT_W-1:0] RUN_COUNT_MAX   = CNT_W'(MAX_RUNS);
  localparam logic [CNT_W-1:0] RUN_COUNT_RESET = CNT_W'(1);

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  new_index;
    logic              went_up;
    logic [STEP_W-1:0] step_total;
    logic              found;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/rtrs_mem.sv
// Run table storage: one write port, one read port with registered data.
// Depends on rtrs_pkg.
`default_nettype none
module rtrs_mem (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [rtrs_pkg::IDX_W-1:0] waddr_i,
  input  wire rtrs_pkg::entry_t         wdata_i,
  input  wire rtrs_pkg::rd_req_t        rd_i,
  output rtrs_pkg::entry_t              rdata_o
);
  import rtrs_pkg::*;

  entry_t mem_q [MAX_RUNS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/rtrs_scan.sv
// Query sequencer: picks the direction, then steps one run per cycle
// through the shared compare/step unit. Depends on rtrs_pkg.
`default_nettype none
module rtrs_scan (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       go_i,
  input  wire logic [rtrs_pkg::IDX_W-1:0] idx_i,
  input  wire logic [rtrs_pkg::SYM_W-1:0] sym_i,
  input  wire logic [rtrs_pkg::OFF_W-1:0] off_i,
  input  wire logic [rtrs_pkg::CNT_W-1:0] run_count_i,
  input  wire rtrs_pkg::entry_t           rdata_i,
  output rtrs_pkg::rd_req_t               rd_o,
  output logic                            busy_o,
  output rtrs_pkg::res_t                  res_o
);
  import rtrs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_SCAN
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  start_q;
  logic [IDX_W-1:0]  last_q;
  logic [IDX_W-1:0]  pos_q;
  logic [SYM_W-1:0]  sym_q;
  logic [OFF_W-1:0]  off_q;
  logic [STEP_W-1:0] cnt_q;
  logic              up_q;
  logic              first_q;
  res_t              res_q;

  logic              in_range;
  logic              at_start;
  logic              at_edge;
  logic              quick_fail;
  logic              hit;
  logic [IDX_W-1:0]  next_pos;
  logic              up_pick;

  assign in_range   = {1'b0, idx_i} < run_count_i;
  assign at_start   = (pos_q == start_q);
  assign at_edge    = up_q ? (pos_q == '0) : (pos_q == last_q);
  // an attempt that starts on its own boundary fails without a compare
  assign quick_fail = at_start && at_edge;
  assign hit        = !quick_fail && (rdata_i.sym == sym_q);
  assign next_pos   = up_q ? (pos_q - IDX_W'(1)) : (pos_q + IDX_W'(1));

  always_comb begin
    up_pick = {off_q, 1'b0} < {1'b0, rdata_i.len};
    if (start_q == '0) begin
      up_pick = 1'b0;
    end
    if (start_q == last_q) begin
      up_pick = 1'b1;
    end
  end

  always_comb begin
    rd_o = '{re: 1'b0, addr: idx_i};
    unique case (state_q)
      S_IDLE: begin
        rd_o.re = go_i && in_range;
      end
      S_LEN: begin
        rd_o.re = 1'b0;
      end
      S_SCAN: begin
        if (!hit && !at_edge) begin
          rd_o = '{re: 1'b1, addr: next_pos};
        end else if (!hit && first_q) begin
          rd_o = '{re: 1'b1, addr: start_q};
        end
      end
      default: rd_o.re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= '0;
      first_q <= 1'b0;
      start_q <= '0;
      last_q  <= '0;
      pos_q   <= '0;
      sym_q   <= '0;
      off_q   <= '0;
      cnt_q   <= '0;
      up_q    <= 1'b0;
    end else begin
      res_q.valid <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (go_i) begin
            start_q <= idx_i;
            sym_q   <= sym_i;
            off_q   <= off_i;
            last_q  <= IDX_W'(run_count_i - CNT_W'(1));
            cnt_q   <= '0;
            if (in_range) begin
              state_q <= S_LEN;
            end else begin
              res_q <= '{valid: 1'b1, new_index: '0, went_up: 1'b0,
                         step_total: '0, found: 1'b0};
            end
          end
        end
        S_LEN: begin
          up_q    <= up_pick;
          pos_q   <= start_q;
          first_q <= 1'b1;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            res_q   <= '{valid: 1'b1, new_index: pos_q, went_up: up_q,
                         step_total: cnt_q, found: 1'b1};
            state_q <= S_IDLE;
          end else if (at_edge) begin
            if (first_q) begin
              first_q <= 1'b0;
              up_q    <= !up_q;
              pos_q   <= start_q;
            end else begin
              res_q   <= '{valid: 1'b1, new_index: '0, went_up: 1'b0,
                           step_total: cnt_q, found: 1'b0};
              state_q <= S_IDLE;
            end
          end else begin
            cnt_q <= cnt_q + STEP_W'(1);
            pos_q <= next_pos;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_o  = res_q;

endmodule
`default_nettype wire

// File: rtl/run_table_reposition_scan.sv
// Top level of the run table reposition scan: config register, table, sequencer.
// Depends on rtrs_pkg, rtrs_mem and rtrs_scan.
//
//  channel  | handshake                       | word
//  ---------+---------------------------------+--------------------------------------
//  command  | start, busy (taken: start&!busy)| action, run_slot, symbol, run_length,
//           |                                 | query_offset
//  result   | result_valid_o (1-cycle strobe) | new_index, went_up, step_total, found
//  config   | cfg_valid_i, cfg_ready_o        | cfg_data_i -> run_count
//
// A write word is taken while busy is low and leaves busy low. A query word holds busy
// while the start run's length is fetched, then while the scan visits the runs in each
// direction (the start run again when the scan turns around, also for a direction that
// starts on its own boundary). A query outside run_count keeps busy low. The strobe
// comes in the first cycle with busy low. Reset sets run_count to 1; the table is not
// cleared; no receiver stall.
`default_nettype none
module run_table_reposition_scan (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        action_i,
  input  wire logic [rtrs_pkg::IDX_W-1:0]  run_slot_i,
  input  wire logic [rtrs_pkg::SYM_W-1:0]  symbol_i,
  input  wire logic [rtrs_pkg::LEN_W-1:0]  run_length_i,
  input  wire logic [rtrs_pkg::OFF_W-1:0]  query_offset_i,
  output logic                             result_valid_o,
  output logic [rtrs_pkg::IDX_W-1:0]       new_index_o,
  output logic                             went_up_o,
  output logic [rtrs_pkg::STEP_W-1:0]      step_total_o,
  output logic                             found_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [rtrs_pkg::CNT_W-1:0]  cfg_data_i
);
  import rtrs_pkg::*;

  logic [CNT_W-1:0] run_count_q;
  logic             take;
  logic             do_write;
  logic             do_query;
  entry_t           wdata;
  entry_t           rdata;
  rd_req_t          rd_req;
  res_t             res;

  assign cfg_ready_o = 1'b1;

  // counts above the table depth saturate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_count_q <= RUN_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      run_count_q <= (cfg_data_i > RUN_COUNT_MAX) ? RUN_COUNT_MAX : cfg_data_i;
    end
  end

  assign take     = start && !busy;
  assign do_write = take && (action_i == ACT_WRITE);
  assign do_query = take && (action_i == ACT_QUERY);
  assign wdata    = '{sym: symbol_i, len: run_length_i};

  rtrs_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (run_slot_i),
    .wdata_i (wdata),
    .rd_i    (rd_req),
    .rdata_o (rdata)
  );

  rtrs_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (do_query),
    .idx_i       (run_slot_i),
    .sym_i       (symbol_i),
    .off_i       (query_offset_i),
    .run_count_i (run_count_q),
    .rdata_i     (rdata),
    .rd_o        (rd_req),
    .busy_o      (busy),
    .res_o       (res)
  );

  assign result_valid_o = res.valid;
  assign new_index_o    = res.new_index;
  assign went_up_o      = res.went_up;
  assign step_total_o   = res.step_total;
  assign found_o        = res.found;

endmodule
`default_nettype wire

// File: dv/run_table_reposition_scan_tb.sv
// Self-checking testbench for run_table_reposition_scan: directed table, then random words.
// Depends on rtrs_pkg and the run_table_reposition_scan rtl; needs nothing else.
module run_table_reposition_scan_tb;
  import rtrs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 10_000_000;
  localparam int unsigned RANDOM_WORDS = 900;
  localparam int unsigned DRAIN_PAUSE  = 4;

  // one expected answer of a query word
  typedef struct packed {
    logic [IDX_W-1:0]  new_index;
    logic              went_up;
    logic [STEP_W-1:0] step_total;
    logic              found;
  } scan_answer_t;

  // directed plan: a run_count write, a word checked by the predictor, or a word
  // whose answer is typed in below
  typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CNT_W-1:0]  cfg_word;
    logic              act;
    logic [IDX_W-1:0]  idx;
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    logic [OFF_W-1:0]  off;
    logic [IDX_W-1:0]  x_index;
    logic              x_up;
    logic [STEP_W-1:0] x_count;
    logic              x_found;
  } dir_row_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  logic              action_i       = ACT_WRITE;
  logic [IDX_W-1:0]  run_slot_i     = '0;
  logic [SYM_W-1:0]  symbol_i       = '0;
  logic [LEN_W-1:0]  run_length_i   = '0;
  logic [OFF_W-1:0]  query_offset_i = '0;
  logic              result_valid_o;
  logic [IDX_W-1:0]  new_index_o;
  logic              went_up_o;
  logic [STEP_W-1:0] step_total_o;
  logic              found_o;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  logic [CNT_W-1:0]  cfg_data_i     = '0;

  // shadow of the run table; written[] tracks entries a query may safely touch
  logic [SYM_W-1:0]  sym_tab [MAX_RUNS];
  logic [LEN_W-1:0]  len_tab [MAX_RUNS];
  bit                written [MAX_RUNS];
  int unsigned       run_count_q = 1;

  scan_answer_t      pending_answers [$];
  int unsigned       mismatches  = 0;
  int unsigned       cycle_count = 0;
  int unsigned       words_taken = 0;
  int unsigned       gap_pct     = 14;

  // After reset run_count is 1. Entries 0, 1, 2, 4094 and 4095 get written before
  // anything reads them; every query below stays inside those.
  dir_row_t plan [0:24] = '{
    // reset value: start 5 is outside a single run
    '{ROW_TYPED, 0,    ACT_QUERY, 5,    8'h00, 0,     0,     0,    0, 0, 0},
    // zero run length on entry 0
    '{ROW_PRED,  0,    ACT_WRITE, 0,    8'h00, 0,     0,     0,    0, 0, 0},
    // single run: both directions fail at once, no steps
    '{ROW_TYPED, 0,    ACT_QUERY, 0,    8'h00, 0,     0,     0,    0, 0, 0},
    // all ones saturates to the table size
    '{ROW_CFG,   8191, ACT_WRITE, 0,    8'h00, 0,     0,     0,    0, 0, 0},
    '{ROW_PRED,  0,    ACT_WRITE, 4095, 8'hFF, 65535, 0,     0,    0, 0, 0},
    '{ROW_PRED,  0,    ACT_WRITE, 4094, 8'hAA, 1,     65535, 0,    0, 0, 0},
    // last run forces the scan toward lower indices
    '{ROW_TYPED, 0,    ACT_QUERY, 4095, 8'hAA, 0,     65535, 4094, 1, 1, 1},
    '{ROW_TYPED, 0,    ACT_QUERY, 4095, 8'hFF, 0,     0,     4095, 1, 0, 1},
    '{ROW_PRED,  0,    ACT_WRITE, 1,    8'h55, 65535, 0,     0,    0, 0, 0},
    '{ROW_PRED,  0,    ACT_WRITE, 2,    8'h00, 2,     0,     0,    0, 0, 0},
    // index 0 forces the scan toward higher indices
    '{ROW_TYPED, 0,    ACT_QUERY, 0,    8'h55, 0,     65535, 1,    0, 1, 1},
    '{ROW_TYPED, 0,    ACT_QUERY, 0,    8'h00, 0,     0,     0,    0, 0, 1},
    '{ROW_CFG,   3,    ACT_WRITE, 0,    8'h00, 0,     0,     0,    0, 0, 0},
    // offset picks the direction, both ways
    '{ROW_PRED,  0,    ACT_QUERY, 1,    8'h00, 0,     0,     0,    0, 0, 0},
    '{ROW_PRED,  0,    ACT_QUERY, 1,    8'h00, 0,     16'h8000, 0, 0, 0, 0},
    // symbol nowhere: both attempts walk to their end
    '{ROW_PRED,  0,    ACT_QUERY, 1,    8'h77, 0,     0,     0,    0, 0, 0},
    '{ROW_PRED,  0,    ACT_QUERY, 2,    8'h77, 0,     16'h1234, 0, 0, 0, 0},
    // start at or past run_count
    '{ROW_TYPED, 0,    ACT_QUERY, 3,    8'h00, 0,     0,     0,    0, 0, 0},
    '{ROW_TYPED, 0,    ACT_QUERY, 4095, 8'hFF, 0,     65535, 0,    0, 0, 0},
    // zero runs fails everything
    '{ROW_CFG,   0,    ACT_WRITE, 0,    8'h00, 0,     0,     0,    0, 0, 0},
    '{ROW_TYPED, 0,    ACT_QUERY, 0,    8'h00, 0,     0,     0,    0, 0, 0},
    '{ROW_CFG,   4096, ACT_WRITE, 0,    8'h00, 0,     0,     0,    0, 0, 0},
    '{ROW_PRED,  0,    ACT_QUERY, 4094, 8'hFF, 0,     1,     0,    0, 0, 0},
    '{ROW_PRED,  0,    ACT_QUERY, 2,    8'h00, 0,     0,     0,    0, 0, 0},
    '{ROW_PRED,  0,    ACT_QUERY, 2,    8'h00, 0,     1,     0,    0, 0, 0}
  };

  run_table_reposition_scan dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .run_slot_i     (run_slot_i),
    .symbol_i       (symbol_i),
    .run_length_i   (run_length_i),
    .query_offset_i (query_offset_i),
    .result_valid_o (result_valid_o),
    .new_index_o    (new_index_o),
    .went_up_o      (went_up_o),
    .step_total_o   (step_total_o),
    .found_o        (found_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Walk toward index 0; fails at once when starting there. Tracks lowest entry read.
  function automatic bit scan_lower(input int unsigned from, input logic [SYM_W-1:0] want_sym,
                                    inout int unsigned steps, inout int unsigned lowest,
                                    output int unsigned at);
    int unsigned i;
    i  = from;
    at = from;
    if (from == 0) return 1'b0;
    while (i > 0 && sym_tab[i] != want_sym) begin
      steps = steps + 1;
      i     = i - 1;
    end
    if (i < lowest) lowest = i;
    at = i;
    return sym_tab[i] == want_sym;
  endfunction

  // Walk toward the last run in use; fails at once when starting on it.
  function automatic bit scan_higher(input int unsigned from, input logic [SYM_W-1:0] want_sym,
                                     input int unsigned last, inout int unsigned steps,
                                     inout int unsigned highest, output int unsigned at);
    int unsigned i;
    i  = from;
    at = from;
    if (from == last) return 1'b0;
    while (i < last && sym_tab[i] != want_sym) begin
      steps = steps + 1;
      i     = i + 1;
    end
    if (i > highest) highest = i;
    at = i;
    return sym_tab[i] == want_sym;
  endfunction

  // Answer of one query against the shadow table; lo..hi is the span of entries read.
  function automatic scan_answer_t predict_reposition(input logic [IDX_W-1:0] idx,
                                                      input logic [SYM_W-1:0] want_sym,
                                                      input logic [OFF_W-1:0] off,
                                                      output int unsigned lo,
                                                      output int unsigned hi);
    scan_answer_t ans;
    int unsigned  last;
    int unsigned  steps;
    int unsigned  at;
    bit           up;
    bit           hit;
    ans   = '0;
    lo    = idx;
    hi    = idx;
    steps = 0;
    at    = 0;
    if (idx >= run_count_q) return ans;
    last = run_count_q - 1;
    up   = (32'(off) * 2) < 32'(len_tab[idx]);
    // the end runs override the offset test; last run wins on a single run
    if (idx == last) up = 1'b1;
    if (idx == 0)    up = 1'b0;
    if (idx == last) up = 1'b1;
    if (up) begin
      hit = scan_lower(idx, want_sym, steps, lo, at);
      if (!hit) begin
        up  = 1'b0;
        hit = scan_higher(idx, want_sym, last, steps, hi, at);
      end
    end else begin
      hit = scan_higher(idx, want_sym, last, steps, hi, at);
      if (!hit) begin
        up  = 1'b1;
        hit = scan_lower(idx, want_sym, steps, lo, at);
      end
    end
    ans.step_total = steps[STEP_W-1:0];
    if (hit) begin
      ans.new_index = at[IDX_W-1:0];
      ans.went_up   = up;
      ans.found     = 1'b1;
    end
    return ans;
  endfunction

  // Drop start, let every answer come home, then give the block a short pause.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0 || busy);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  task automatic set_run_count(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    run_count_q = (value > MAX_RUNS) ? MAX_RUNS : value;
  endtask

  // Present one word, hold it until taken, then update the shadow or queue the answer.
  // start stays high into the next word unless a gap is drawn.
  task automatic send_word(input logic act, input logic [IDX_W-1:0] idx,
                           input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                           input logic [OFF_W-1:0] off, input bit typed,
                           input scan_answer_t typed_ans);
    int unsigned lo;
    int unsigned hi;
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    action_i       <= act;
    run_slot_i     <= idx;
    symbol_i       <= sym;
    run_length_i   <= len;
    query_offset_i <= off;
    // busy read here is its value before the edge, i.e. the one the block used
    do @(posedge clk_i); while (busy);
    if (act == ACT_WRITE) begin
      sym_tab[idx] = sym;
      len_tab[idx] = len;
      written[idx] = 1'b1;
    end else if (typed) begin
      pending_answers.push_back(typed_ans);
    end else begin
      pending_answers.push_back(predict_reposition(idx, sym, off, lo, hi));
    end
    words_taken++;
  endtask

  // Result strobe is one cycle wide and cannot be stalled: check on every edge.
  always @(posedge clk_i) begin : answer_check
    scan_answer_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_answers.size() == 0) begin
        $error("result word with no query waiting: index %0d", new_index_o);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (new_index_o !== want.new_index) begin
          $error("new_index: expected %0d, got %0d", want.new_index, new_index_o);
          mismatches++;
        end
        if (went_up_o !== want.went_up) begin
          $error("went_up: expected %0d, got %0d", want.went_up, went_up_o);
          mismatches++;
        end
        if (step_total_o !== want.step_total) begin
          $error("step_total: expected %0d, got %0d", want.step_total, step_total_o);
          mismatches++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t         row;
    scan_answer_t     typed_ans;
    logic [SYM_W-1:0] alpha [4];
    logic [CNT_W-1:0] cfg_pick;
    logic [IDX_W-1:0] q_idx;
    logic [SYM_W-1:0] q_sym;
    logic [OFF_W-1:0] q_off;
    int unsigned      lo_w;
    int unsigned      hi_w;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      tries;
    bit               ok;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (plan[k]) begin
      row = plan[k];
      if (row.kind == ROW_CFG) begin
        set_run_count(row.cfg_word);
      end else begin
        typed_ans = '{row.x_index, row.x_up, row.x_count, row.x_found};
        send_word(row.act, row.idx, row.sym, row.len, row.off, row.kind == ROW_TYPED,
                  typed_ans);
      end
    end

    // Random part: segments of one run_count each. A segment fills a window of the
    // table with symbols from a small alphabet so scans actually hit, then mixes
    // queries with a few rewrites and out-of-range starts.
    words_taken = 0;
    while (words_taken < RANDOM_WORDS) begin
      // sender idles 14 %, then 77 %, then not at all
      gap_pct = (words_taken < RANDOM_WORDS / 3) ? 14 :
                (words_taken < 2 * RANDOM_WORDS / 3) ? 77 : 0;
      case ($urandom_range(0, 19))
        0:       cfg_pick = '0;
        1:       cfg_pick = RUN_COUNT_MAX;
        2:       cfg_pick = '1;
        3:       cfg_pick = CNT_W'($urandom_range(MAX_RUNS + 1, 8191));
        4, 5:    cfg_pick = CNT_W'($urandom_range(33, MAX_RUNS - 1));
        default: cfg_pick = CNT_W'($urandom_range(1, 32));
      endcase
      set_run_count(cfg_pick);

      // small tables are filled whole; large ones get a 16-entry window
      if (run_count_q <= 64) begin
        lo_w = 0;
        hi_w = (run_count_q == 0) ? 7 : run_count_q - 1;
      end else begin
        lo_w = $urandom_range(0, run_count_q - 16);
        hi_w = lo_w + 15;
      end
      foreach (alpha[a]) alpha[a] = SYM_W'($urandom_range(0, 255));

      for (int unsigned e = lo_w; e <= hi_w; e++) begin
        q_sym = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : alpha[$urandom_range(0, 3)];
        send_word(ACT_WRITE, IDX_W'(e), q_sym, LEN_W'($urandom_range(0, 65535)),
                  OFF_W'($urandom_range(0, 65535)), 1'b0, '0);
      end

      repeat ($urandom_range(10, 40)) begin
        if ($urandom_range(0, 9) == 0) begin
          // rewrite inside the window between queries
          q_sym = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : alpha[$urandom_range(0, 3)];
          send_word(ACT_WRITE, IDX_W'($urandom_range(lo_w, hi_w)), q_sym,
                    LEN_W'($urandom_range(0, 65535)), OFF_W'($urandom_range(0, 65535)),
                    1'b0, '0);
        end else begin
          // draw until the scan stays on written entries; give up after a few tries
          ok    = 1'b0;
          tries = 0;
          while (!ok && tries < 8) begin
            tries++;
            if ($urandom_range(0, 8) == 0 && run_count_q < MAX_RUNS)
              q_idx = IDX_W'($urandom_range(run_count_q, MAX_RUNS - 1));
            else
              q_idx = IDX_W'($urandom_range(lo_w, hi_w));
            q_sym = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                : alpha[$urandom_range(0, 3)];
            q_off = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                    : 16'($urandom_range(0, written[q_idx] ? len_tab[q_idx] : 0));
            void'(predict_reposition(q_idx, q_sym, q_off, lo, hi));
            ok = 1'b1;
            if (q_idx < run_count_q) begin
              for (int unsigned e = lo; e <= hi; e++)
                if (!written[e]) ok = 1'b0;
            end
          end
          if (ok)
            send_word(ACT_QUERY, q_idx, q_sym, LEN_W'($urandom_range(0, 65535)), q_off,
                      1'b0, '0);
        end
      end
    end

    // drain, then a tail for anything stray
    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
